// ===== hdl/kti_pkg.sv =====
// Shared types and constants for the keyframe track interpolator.
`timescale 1ns / 1ps
package kti_pkg;

  localparam int MAX_FRAMES = 1024;
  localparam int CHANNELS   = 26;
  localparam int FIDX_W     = 10;
  localparam int WADDR_W    = 15;
  localparam int TIME_W     = 22;
  localparam int CH_W       = 5;
  localparam int WORD_W     = 32;
  localparam int FRAC_W     = 16;

  localparam logic [1:0] CMD_TIME  = 2'd0;
  localparam logic [1:0] CMD_WORD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [CH_W-1:0] LAST_CH     = 5'd25;
  localparam logic [CH_W-1:0] LAST_LERPCH = 5'd12;

  localparam logic [33:0] HALF_TURN  = 34'd46080;
  localparam logic [33:0] WRAP_BIAS  = 34'd4295024640;
  localparam logic [6:0]  TURN_STEPS = 7'd45;

  typedef struct packed {
    logic [1:0]               command;
    logic [FIDX_W-1:0]        frame_index;
    logic [CH_W-1:0]          channel_select;
    logic signed [WORD_W-1:0] word_value;
    logic [TIME_W-1:0]        time_ms;
  } kti_in_t;

  typedef struct packed {
    logic [CH_W-1:0]          channel_out;
    logic signed [WORD_W-1:0] sample_value;
    logic [TIME_W-1:0]        sample_time;
    logic                     last_channel;
  } kti_out_t;

  function automatic logic [WADDR_W-1:0] times26(input logic [FIDX_W-1:0] f);
    times26 = WADDR_W'({f, 4'b0}) + WADDR_W'({f, 3'b0}) + WADDR_W'({f, 1'b0});
  endfunction

endpackage

// ===== hdl/kti_div.sv =====
// Restoring divider producing the 16-bit interpolation fraction, one bit per cycle.
`timescale 1ns / 1ps
module kti_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [kti_pkg::TIME_W-1:0]  offset,
  input  logic [kti_pkg::TIME_W-1:0]  span,
  output logic                        done,
  output logic [kti_pkg::FRAC_W-1:0]  quo
);
  import kti_pkg::*;

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [4:0]        cnt;
  logic              run;
  logic [TIME_W:0]   sh;

  assign sh = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 5'(FRAC_W);
        rem <= offset;
        dvs <= span;
      end else if (run) begin
        if (sh >= {1'b0, dvs}) begin
          rem <= TIME_W'(sh - {1'b0, dvs});
          quo <= {quo[FRAC_W-2:0], 1'b1};
        end else begin
          rem <= sh[TIME_W-1:0];
          quo <= {quo[FRAC_W-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/kti_lerp.sv =====
// Channel blend unit: difference, angle wrap, multiply by fraction, floor and saturate.
`timescale 1ns / 1ps
module kti_lerp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  logic                               is_angle,
  input  logic signed [kti_pkg::WORD_W-1:0]  a,
  input  logic signed [kti_pkg::WORD_W-1:0]  b,
  input  logic [kti_pkg::FRAC_W-1:0]         frac,
  output logic                               done,
  output logic signed [kti_pkg::WORD_W-1:0]  value
);
  import kti_pkg::*;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_MOD  = 2'd1;
  localparam logic [1:0] L_MUL  = 2'd2;
  localparam logic [1:0] L_ADD  = 2'd3;

  logic [1:0]         state;
  logic [1:0]         cnt;
  logic signed [31:0] a_q;
  logic signed [32:0] d_q;
  logic [23:0]        qsh;
  logic [5:0]         rem;
  logic [10:0]        low;
  logic signed [49:0] prod;
  logic signed [32:0] diff;
  logic [33:0]        xs;
  logic [6:0]         r_step [0:8];
  logic [16:0]        m;
  logic signed [33:0] sum;

  assign diff = 33'(b) - 33'(a);
  assign xs   = 34'(signed'(diff)) + HALF_TURN + WRAP_BIAS;
  assign m    = {r_step[8][5:0], low};
  assign sum  = 34'(a_q) + 34'(prod >>> FRAC_W);

  always_comb begin
    r_step[0] = {1'b0, rem};
    for (int i = 0; i < 8; i++) begin
      r_step[i+1] = {r_step[i][5:0], qsh[23-i]};
      if (r_step[i+1] >= TURN_STEPS) begin
        r_step[i+1] = r_step[i+1] - TURN_STEPS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
      cnt   <= 2'd0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (go) begin
            a_q <= a;
            if (is_angle) begin
              qsh   <= {1'b0, xs[33:11]};
              low   <= xs[10:0];
              rem   <= 6'd0;
              cnt   <= 2'd2;
              state <= L_MOD;
            end else begin
              d_q   <= diff;
              state <= L_MUL;
            end
          end
        end
        L_MOD: begin
          rem <= r_step[8][5:0];
          qsh <= {qsh[15:0], 8'b0};
          cnt <= cnt - 2'd1;
          if (cnt == 2'd0) begin
            d_q   <= 33'(signed'({1'b0, m})) - 33'sd46080;
            state <= L_MUL;
          end
        end
        L_MUL: begin
          prod  <= d_q * signed'({1'b0, frac});
          state <= L_ADD;
        end
        L_ADD: begin
          if (sum > 34'sd2147483647) begin
            value <= 32'sh7FFFFFFF;
          end else if (sum < -34'sd2147483648) begin
            value <= 32'sh80000000;
          end else begin
            value <= sum[31:0];
          end
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/keyframe_track_interpolator.sv =====
// Top level: keyframe stores, binary search sequencer and result output.
//
//  channel   ports                        handshake
//  --------  ---------------------------  -----------------------------
//  command   cmd, start, busy             transfer when start & !busy
//  result    result, result_valid         one-cycle strobe, no backpressure
//  config    frame_count, frame_count_we  write when frame_count_we
//
// Write commands complete in the accept cycle and leave busy low.
// A query runs at most 11 binary search steps, fetches the frame pair, computes the
// fraction when interpolating, then emits one channel at a time, held channels direct
// and linear and angle channels through the shared blend unit, as the word store has a
// single read port. The receiver never stalls.
// Synchronous reset sets frame_count to 1; the stores are not cleared.
`timescale 1ns / 1ps
module keyframe_track_interpolator (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  kti_pkg::kti_in_t  cmd,
  input  logic              frame_count_we,
  input  logic [10:0]       frame_count,
  output logic              result_valid,
  output kti_pkg::kti_out_t result
);
  import kti_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MID   = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_FA    = 4'd3;
  localparam logic [3:0] S_FB    = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DIVW  = 4'd6;
  localparam logic [3:0] S_RA    = 4'd7;
  localparam logic [3:0] S_RB    = 4'd8;
  localparam logic [3:0] S_LERP  = 4'd9;
  localparam logic [3:0] S_LERPW = 4'd10;

  logic [TIME_W-1:0] frame_times [0:MAX_FRAMES-1];
  logic [WORD_W-1:0] channel_words [0:MAX_FRAMES*CHANNELS-1];

  logic [3:0]         state;
  logic [10:0]        fcount;
  logic [10:0]        lo, hi, n;
  logic [FIDX_W-1:0]  mid, fa;
  logic [TIME_W-1:0]  t, ta, rtime;
  logic               interp;
  logic [CH_W-1:0]    ch;
  logic [WADDR_W-1:0] base_a, base_b;
  logic [FRAC_W-1:0]  frac;
  logic signed [31:0] a_word;

  logic [TIME_W-1:0]  ft_q;
  logic [WORD_W-1:0]  w_q;
  logic [FIDX_W-1:0]  ft_raddr;
  logic [WADDR_W-1:0] w_raddr;
  logic               accept;
  logic [10:0]        mid_full;
  logic               lerp_ch;

  logic               div_go, div_done;
  logic [FRAC_W-1:0]  div_q;
  logic               lerp_go, lerp_done;
  logic signed [31:0] lerp_v;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign mid_full = lo + ((hi - lo) >> 1);
  assign lerp_ch  = interp && (ch <= LAST_LERPCH);

  always_comb begin
    case (state)
      S_MID:   ft_raddr = mid_full[FIDX_W-1:0];
      S_FA:    ft_raddr = (lo == 11'd0) ? '0 : FIDX_W'(lo - 11'd1);
      default: ft_raddr = lo[FIDX_W-1:0];
    endcase
    w_raddr = (state == S_RA) ? base_a + WADDR_W'(ch) : base_b + WADDR_W'(ch);
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.command == CMD_TIME) begin
      frame_times[cmd.frame_index] <= cmd.time_ms;
    end
    ft_q <= frame_times[ft_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.command == CMD_WORD && cmd.channel_select <= LAST_CH) begin
      channel_words[times26(cmd.frame_index) + WADDR_W'(cmd.channel_select)] <= cmd.word_value;
    end
    w_q <= channel_words[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount <= 11'd1;
    end else if (frame_count_we) begin
      fcount <= frame_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      div_go       <= 1'b0;
      lerp_go      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      div_go       <= 1'b0;
      lerp_go      <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && cmd.command == CMD_QUERY) begin
            t  <= cmd.time_ms;
            lo <= 11'd0;
            if (fcount == 11'd0) begin
              hi <= 11'd1;
              n  <= 11'd1;
            end else if (fcount > 11'(MAX_FRAMES)) begin
              hi <= 11'(MAX_FRAMES);
              n  <= 11'(MAX_FRAMES);
            end else begin
              hi <= fcount;
              n  <= fcount;
            end
            state <= S_MID;
          end
        end
        S_MID: begin
          mid   <= mid_full[FIDX_W-1:0];
          state <= (lo < hi) ? S_CMP : S_FA;
        end
        S_CMP: begin
          if (t < ft_q) begin
            hi <= {1'b0, mid};
          end else begin
            lo <= {1'b0, mid} + 11'd1;
          end
          state <= S_MID;
        end
        S_FA: begin
          fa    <= ft_raddr;
          state <= S_FB;
        end
        S_FB: begin
          ta     <= ft_q;
          interp <= (lo != 11'd0) && (ft_q != t) && (lo != n);
          rtime  <= ((lo != 11'd0) && (ft_q != t) && (lo != n)) ? t : ft_q;
          base_a <= times26(fa);
          state  <= S_DIV;
        end
        S_DIV: begin
          base_b <= times26(lo[FIDX_W-1:0]);
          ch     <= '0;
          if (interp) begin
            div_go <= 1'b1;
            state  <= S_DIVW;
          end else begin
            state <= S_RA;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            frac  <= div_q;
            state <= S_RA;
          end
        end
        S_RA: begin
          state <= S_RB;
        end
        S_RB: begin
          a_word <= w_q;
          if (lerp_ch) begin
            state <= S_LERP;
          end else begin
            result_valid        <= 1'b1;
            result.channel_out  <= ch;
            result.sample_value <= w_q;
            result.sample_time  <= rtime;
            result.last_channel <= (ch == LAST_CH);
            ch    <= ch + 5'd1;
            state <= (ch == LAST_CH) ? S_IDLE : S_RA;
          end
        end
        S_LERP: begin
          lerp_go <= 1'b1;
          state   <= S_LERPW;
        end
        S_LERPW: begin
          if (lerp_done) begin
            result_valid        <= 1'b1;
            result.channel_out  <= ch;
            result.sample_value <= lerp_v;
            result.sample_time  <= rtime;
            result.last_channel <= (ch == LAST_CH);
            ch    <= ch + 5'd1;
            state <= S_RA;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic signed [31:0] b_word;
  assign b_word = w_q;

  kti_div u_div (
    .clk    (clk),
    .rst    (rst),
    .go     (div_go),
    .offset (TIME_W'(t - ta)),
    .span   (TIME_W'(ft_q - ta)),
    .done   (div_done),
    .quo    (div_q)
  );

  logic [WORD_W-1:0] b_hold;
  always_ff @(posedge clk) begin
    if (state == S_LERP) begin
      b_hold <= b_word;
    end
  end

  kti_lerp u_lerp (
    .clk      (clk),
    .rst      (rst),
    .go       (lerp_go),
    .is_angle (ch inside {[5'd6:5'd8]}),
    .a        (a_word),
    .b        (signed'(b_hold)),
    .frac     (frac),
    .done     (lerp_done),
    .value    (lerp_v)
  );
endmodule

// ===== tb/keyframe_track_interpolator_checker.sv =====
// Checker for the keyframe track interpolator: track model, sample prediction and compare.
`timescale 1ns / 1ps
module kti_track_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  kti_pkg::kti_in_t  cmd,
  input  logic              frame_count_we,
  input  logic [10:0]       frame_count,
  input  logic              result_valid,
  input  kti_pkg::kti_out_t result,
  output int                errors,
  output int                pending
);
  import kti_pkg::*;

  logic [TIME_W-1:0] key_times [MAX_FRAMES];
  logic [WORD_W-1:0] key_words [MAX_FRAMES*CHANNELS];
  logic [10:0]       loaded_frames;
  kti_out_t          expected_samples [$];

  function automatic void predict_samples(input logic [TIME_W-1:0] t);
    int unsigned n, lo, hi, mid, fa, fb, ch;
    bit interp;
    longint unsigned span, off, frac;
    longint a, b, d, p, v;
    logic [TIME_W-1:0] rtime;
    kti_out_t s;
    n = (loaded_frames == 0) ? 1 : (loaded_frames > MAX_FRAMES) ? MAX_FRAMES : loaded_frames;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (t < key_times[mid]) hi = mid;
      else lo = mid + 1;
    end
    fb = 0;
    frac = 0;
    interp = 0;
    if (lo == 0) begin
      fa = 0;
    end else begin
      fa = lo - 1;
      interp = !(key_times[fa] == t || lo == n);
      if (interp) begin
        fb = lo;
        span = longint'(key_times[fb]) - longint'(key_times[fa]);
        off = longint'(t) - longint'(key_times[fa]);
        frac = (span != 0) ? ((off << 16) / span) : 0;
        if (frac > 65535) frac = 65535;
      end
    end
    rtime = interp ? t : key_times[fa];
    for (ch = 0; ch < CHANNELS; ch++) begin
      a = longint'($signed(key_words[fa*CHANNELS+ch]));
      v = a;
      if (interp && ch <= LAST_LERPCH) begin
        b = longint'($signed(key_words[fb*CHANNELS+ch]));
        if (ch >= 6 && ch <= 8) begin
          d = (b - a + 46080) % 92160;
          if (d < 0) d += 92160;
          d -= 46080;
        end else begin
          d = b - a;
        end
        p = d * longint'(frac);
        v = a + (p >>> 16);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
      end
      s.channel_out  = CH_W'(ch);
      s.sample_value = v[WORD_W-1:0];
      s.sample_time  = rtime;
      s.last_channel = (ch == LAST_CH);
      expected_samples.insert(expected_samples.size(), s);
    end
  endfunction

  always @(posedge clk) begin
    kti_out_t exp_s;
    if (rst) begin
      loaded_frames <= 11'd1;
      expected_samples.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (result_valid) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample ch=%0d val=%h time=%0d last=%b", $time,
                   result.channel_out, result.sample_value, result.sample_time,
                   result.last_channel);
          errors <= errors + 1;
        end else begin
          exp_s = expected_samples.pop_front();
          if (result.channel_out !== exp_s.channel_out ||
              result.sample_value !== exp_s.sample_value ||
              result.sample_time !== exp_s.sample_time ||
              result.last_channel !== exp_s.last_channel) begin
            $display("%0t: mismatch expected ch=%0d val=%h time=%0d last=%b", $time,
                     exp_s.channel_out, exp_s.sample_value, exp_s.sample_time,
                     exp_s.last_channel);
            $display("%0t:          actual   ch=%0d val=%h time=%0d last=%b", $time,
                     result.channel_out, result.sample_value, result.sample_time,
                     result.last_channel);
            errors <= errors + 1;
          end
        end
      end
      if (frame_count_we) loaded_frames <= frame_count;
      if (start && !busy) begin
        case (cmd.command)
          CMD_TIME:  key_times[cmd.frame_index] <= cmd.time_ms;
          CMD_WORD: begin
            if (cmd.channel_select < CHANNELS)
              key_words[cmd.frame_index*CHANNELS + cmd.channel_select] <= cmd.word_value;
          end
          CMD_QUERY: predict_samples(cmd.time_ms);
          default: ;
        endcase
      end
      pending <= expected_samples.size();
    end
  end

endmodule

// ===== tb/keyframe_track_interpolator_test.sv =====
// Testbench top: clock, reset, track loading, query stimulus and verdict.
`timescale 1ns / 1ps
module keyframe_track_interpolator_test;
  import kti_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int TRACK_FRAMES = 4;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  kti_in_t cmd = '0;
  logic frame_count_we = 0;
  logic [10:0] frame_count = 11'd1;
  logic result_valid;
  kti_out_t result;
  int errors, pending;
  bit gaps_on = 1;
  int track_len = 1;
  logic [TIME_W-1:0] shadow_times [MAX_FRAMES];

  always #6 clk = ~clk;

  keyframe_track_interpolator dut (.*);

  kti_track_checker checker_i (.*);

  task automatic transfer(input logic [1:0] op, input int f, input int ch,
                          input logic [31:0] w, input int t);
    start <= 1;
    cmd.command <= op;
    cmd.frame_index <= FIDX_W'(f);
    cmd.channel_select <= CH_W'(ch);
    cmd.word_value <= w;
    cmd.time_ms <= TIME_W'(t);
    do @(posedge clk); while (busy);
    if (op == CMD_TIME) shadow_times[f] = TIME_W'(t);
    if (gaps_on && $urandom_range(99) < 9) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_count(input int n);
    settle();
    frame_count_we <= 1;
    frame_count <= 11'(n);
    @(posedge clk);
    frame_count_we <= 0;
    track_len = (n == 0) ? 1 : (n > MAX_FRAMES) ? MAX_FRAMES : n;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 200000)) - 32'd100000;
      default: return $urandom;
    endcase
  endfunction

  task automatic rand_query();
    int f, t;
    f = $urandom_range(track_len - 1);
    case ($urandom_range(5))
      0: t = $urandom_range(3599999);
      1: t = shadow_times[f];
      2: t = shadow_times[f] + 1;
      3: t = (shadow_times[f] == 0) ? 0 : shadow_times[f] - 1;
      default: t = shadow_times[f] + $urandom_range(3499);
    endcase
    if (t > 3599999) t = 3599999;
    transfer(CMD_QUERY, 0, 0, 0, t);
  endtask

  task automatic rand_item();
    int r;
    r = $urandom_range(99);
    if (r < 60) rand_query();
    else if (r < 68) transfer(CMD_TIME, $urandom_range(TRACK_FRAMES - 1), 0, 0,
                              ($urandom_range(3) == 0) ? $urandom_range(3599999)
                              : shadow_times[$urandom_range(TRACK_FRAMES - 1)]);
    else if (r < 96) transfer(CMD_WORD, $urandom_range(track_len), $urandom_range(31),
                              rand_word(), 0);
    else transfer(CMD_NONE, $urandom_range(1023), $urandom_range(31), $urandom,
                  $urandom_range(3599999));
  endtask

  initial begin
    int counts[5];
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // load the track with increasing times
    gaps_on = 0;
    for (int f = 0; f < TRACK_FRAMES; f++) begin
      transfer(CMD_TIME, f, 0, 0, f * 3500 + $urandom_range(1, 100));
      for (int ch = 0; ch < CHANNELS; ch++) transfer(CMD_WORD, f, ch, rand_word(), 0);
    end
    gaps_on = 1;

    set_count(3);
    transfer(CMD_WORD, 0, 0, 32'h7FFF_FFFF, 0);
    transfer(CMD_WORD, 1, 0, 32'h8000_0000, 0);
    transfer(CMD_WORD, 0, 1, 32'h8000_0000, 0);
    transfer(CMD_WORD, 1, 1, 32'h7FFF_FFFF, 0);
    transfer(CMD_WORD, 0, 6, 32'h7FFF_FF00, 0);
    transfer(CMD_WORD, 1, 6, 32'h8000_9000, 0);
    transfer(CMD_WORD, 0, 7, 32'h8000_0100, 0);
    transfer(CMD_WORD, 1, 7, 32'h7FFF_0000, 0);
    transfer(CMD_WORD, 0, 8, 32'd0, 0);
    transfer(CMD_WORD, 1, 8, 32'd46080, 0);
    transfer(CMD_WORD, 2, 30, 32'hDEAD_BEEF, 0);
    transfer(CMD_NONE, 2, 3, 32'hFFFF_FFFF, 3599999);
    transfer(CMD_QUERY, 0, 0, 0, 0);
    transfer(CMD_QUERY, 0, 0, 0, shadow_times[0]);
    transfer(CMD_QUERY, 0, 0, 0, shadow_times[0] + 1);
    transfer(CMD_QUERY, 0, 0, 0, shadow_times[0] + 1750);
    transfer(CMD_QUERY, 0, 0, 0, shadow_times[1] - 1);
    transfer(CMD_QUERY, 0, 0, 0, shadow_times[1]);
    transfer(CMD_QUERY, 0, 0, 0, shadow_times[2] + 5);
    transfer(CMD_QUERY, 0, 0, 0, 3599999);

    counts = '{2, TRACK_FRAMES, 1, 0, 3};
    foreach (counts[i]) begin
      set_count(counts[i]);
      gaps_on = (i != 2);
      for (int k = 0; k < 18; k++) rand_item();
    end

    settle();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("** keyframe_track_interpolator: PASSED **");
    else $display("** keyframe_track_interpolator: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** keyframe_track_interpolator: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/kti_pkg.sv
hdl/kti_div.sv
hdl/kti_lerp.sv
hdl/keyframe_track_interpolator.sv
tb/keyframe_track_interpolator_checker.sv
tb/keyframe_track_interpolator_test.sv
